### rtl/bu2x_pkg.sv
`default_nettype none

package bu2x_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int OUT_BITS    = SAMPLE_BITS + 2;
    localparam int COORD_BITS  = 11;
    localparam int CNT_BITS    = 11;
    localparam int ADDR_BITS   = 3;
    localparam int NUM_KINDS   = 4;

    // reset value of both count registers
    localparam logic [CNT_BITS-1:0] RESET_COUNT = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [OUT_BITS-1:0]    t_value;
    typedef logic [COORD_BITS-1:0]         t_coord;

    // bit 0 set: odd column, bit 1 set: odd row
    typedef enum logic [1:0] {
        KIND_COPY   = 2'd0,
        KIND_LEFT   = 2'd1,
        KIND_ABOVE  = 2'd2,
        KIND_CORNER = 2'd3
    } t_kind;

    // one input's results, handed to the output sequencer
    typedef struct packed {
        logic [NUM_KINDS-1:0]               present;
        logic [NUM_KINDS-1:0][OUT_BITS-1:0] value;
        t_coord                             row_even;
        t_coord                             row_odd;
        t_coord                             col_even;
        t_coord                             col_odd;
        logic                               frame_end;
    } t_em_load;

    function automatic t_value sext(input t_sample s);
        return {{(OUT_BITS-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

endpackage

`default_nettype wire

### rtl/bu2x_line_ram.sv
`default_nettype none

// single-port line memory, read-first: a read returns the contents before the write
module bu2x_line_ram (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [bu2x_pkg::COL_BITS-1:0]    i_addr,
    input  wire logic [bu2x_pkg::SAMPLE_BITS-1:0] i_wdata,
    output logic      [bu2x_pkg::SAMPLE_BITS-1:0] o_rdata
);
    import bu2x_pkg::*;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_COLS];
    logic [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_addr] <= i_wdata;
            r_rdata       <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/bu2x_emitter.sv
`default_nettype none

module bu2x_emitter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load_valid,
    input  wire bu2x_pkg::t_em_load            i_load,
    output logic                               o_load_ready,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [bu2x_pkg::OUT_BITS-1:0]      o_value,
    output logic [bu2x_pkg::COORD_BITS-1:0]    o_row,
    output logic [bu2x_pkg::COORD_BITS-1:0]    o_col,
    output logic                               o_last,
    output logic                               o_frame_done
);
    import bu2x_pkg::*;

    logic [NUM_KINDS-1:0]               r_pend;
    logic [NUM_KINDS-1:0][OUT_BITS-1:0] r_value;
    t_coord                             r_row_even;
    t_coord                             r_row_odd;
    t_coord                             r_col_even;
    t_coord                             r_col_odd;
    logic                               r_frame_end;

    t_kind w_sel;
    logic  w_load;

    // lowest pending kind goes out first
    always_comb begin
        if (r_pend[KIND_COPY]) begin
            w_sel = KIND_COPY;
        end else if (r_pend[KIND_LEFT]) begin
            w_sel = KIND_LEFT;
        end else if (r_pend[KIND_ABOVE]) begin
            w_sel = KIND_ABOVE;
        end else begin
            w_sel = KIND_CORNER;
        end
    end

    assign o_valid      = (r_pend != '0);
    assign o_last       = ((r_pend & (r_pend - NUM_KINDS'(1))) == '0);
    assign o_frame_done = o_last & r_frame_end;
    assign o_value      = r_value[w_sel];
    assign o_row        = w_sel[1] ? r_row_odd : r_row_even;
    assign o_col        = w_sel[0] ? r_col_odd : r_col_even;

    assign o_load_ready = !o_valid || (o_last && i_ready);
    assign w_load       = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_load) begin
            r_pend <= i_load.present;
        end else if (o_valid && i_ready) begin
            r_pend <= r_pend & (r_pend - NUM_KINDS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_value     <= i_load.value;
            r_row_even  <= i_load.row_even;
            r_row_odd   <= i_load.row_odd;
            r_col_even  <= i_load.col_even;
            r_col_odd   <= i_load.col_odd;
            r_frame_end <= i_load.frame_end;
        end
    end

    a_copy_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_pend[KIND_COPY])
        else $error("copied sample not queued first");

    a_corner_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_pend[KIND_CORNER] == (r_pend[KIND_LEFT] && r_pend[KIND_ABOVE])))
        else $error("corner average queued without both midpoints");

    a_copy_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_pend[KIND_COPY]) |-> (!o_row[0] && !o_col[0]))
        else $error("copied sample on odd coordinate");

endmodule

`default_nettype wire

### rtl/bilinear_upscale_2x.sv
`default_nettype none

// channel    | dir | transfer when                      | content
// -----------+-----+------------------------------------+--------------------------------------
// s_axis     | in  | s_axis_tvalid & s_axis_tready      | one input pixel, raster order
// m_axis     | out | m_axis_tvalid & m_axis_tready      | one upscaled sample with coordinates
// apb        | in  | psel & penable & pwrite (write)    | row_count at 0x0, col_count at 0x4
//
// an input pixel gives one to four results, one per cycle on m_axis while m_axis_tready
// is high; the output sequencer is what sets the sustained rate. the first result of an
// input comes after the line memory read, then the load of the output sequencer.
// synchronous active-low reset clears counters and pipeline valids; the line memory
// has no reset and no clearing pass. a stall on m_axis backs up into the pipeline
// stage and then into s_axis_tready; the next pixel is taken while results wait.
module bilinear_upscale_2x (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bu2x_pkg::ADDR_BITS-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [15:0]                       s_axis_tdata,  // pixel
    // output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [39:0]                            m_axis_tdata,  // value_quarters, out_row, out_col
    output logic                                   m_axis_tlast,  // last_of_run
    output logic [0:0]                             m_axis_tuser   // frame_done
);
    import bu2x_pkg::*;

    // configuration registers
    logic [CNT_BITS-1:0] r_row_count;
    logic [CNT_BITS-1:0] r_col_count;

    // position of the next input pixel
    logic [ROW_BITS-1:0] r_row_pos;
    logic [COL_BITS-1:0] r_col_pos;

    // stage 1: pixel with its line memory read done, waiting for the output sequencer
    logic                r_s1_valid;
    t_sample             r_s1_pixel;
    logic [ROW_BITS-1:0] r_s1_row;
    logic [COL_BITS-1:0] r_s1_col;
    logic                r_s1_frame_end;

    // neighbours of the pixel in stage 1
    t_sample             r_left;
    t_sample             r_above_left;

    logic                w_cfg_write;
    logic                w_reg_idx;
    logic                w_s_accept;
    logic                w_s1_adv;
    logic                w_em_ready;
    logic [COL_BITS:0]   w_cols;
    logic [ROW_BITS:0]   w_rows;
    logic                w_col_wrap;
    logic                w_row_wrap;
    t_sample             w_above;
    t_value              w_p;
    t_value              w_l;
    t_value              w_a;
    t_value              w_al;
    t_value              w_sum_left;
    t_value              w_sum_above;
    t_coord              w_row2;
    t_coord              w_col2;
    t_em_load            w_load;
    logic [OUT_BITS-1:0] w_out_value;
    t_coord              w_out_row;
    t_coord              w_out_col;
    logic                w_out_last;
    logic                w_out_frame;

    // ---------------------------------------------------------------- config port
    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[ADDR_BITS-1];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RESET_COUNT;
            r_col_count <= RESET_COUNT;
        end else if (w_cfg_write) begin
            if (w_reg_idx == REG_ROW_COUNT) begin
                r_row_count <= pwdata[CNT_BITS-1:0];
            end else begin
                r_col_count <= pwdata[CNT_BITS-1:0];
            end
        end
    end

    assign prdata = (w_reg_idx == REG_COL_COUNT) ? 32'(r_col_count) : 32'(r_row_count);

    // zero acts as one, anything above the maximum saturates
    always_comb begin
        if (r_col_count == '0) begin
            w_cols = (COL_BITS+1)'(1);
        end else if (32'(r_col_count) > 32'(MAX_COLS)) begin
            w_cols = (COL_BITS+1)'(MAX_COLS);
        end else begin
            w_cols = (COL_BITS+1)'(r_col_count);
        end
        if (r_row_count == '0) begin
            w_rows = (ROW_BITS+1)'(1);
        end else if (32'(r_row_count) > 32'(MAX_ROWS)) begin
            w_rows = (ROW_BITS+1)'(MAX_ROWS);
        end else begin
            w_rows = (ROW_BITS+1)'(r_row_count);
        end
    end

    // ---------------------------------------------------------------- stage 0
    assign w_s1_adv      = r_s1_valid && w_em_ready;
    assign s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_s_accept    = s_axis_tvalid && s_axis_tready;

    // counters wrap once they reach or pass the current count
    assign w_col_wrap = ({1'b0, r_col_pos} + (COL_BITS+1)'(1)) >= w_cols;
    assign w_row_wrap = ({1'b0, r_row_pos} + (ROW_BITS+1)'(1)) >= w_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (w_s_accept) begin
            if (w_col_wrap) begin
                r_col_pos <= '0;
                r_row_pos <= w_row_wrap ? '0 : r_row_pos + ROW_BITS'(1);
            end else begin
                r_col_pos <= r_col_pos + COL_BITS'(1);
            end
        end
    end

    // read the pixel above and store this one in the same access; the read
    // data holds until the next transfer, so a stalled stage 1 keeps it
    bu2x_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_en    (w_s_accept),
        .i_addr  (r_col_pos),
        .i_wdata (s_axis_tdata),
        .o_rdata (w_above)
    );

    // ---------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_s1_pixel     <= s_axis_tdata;
            r_s1_row       <= r_row_pos;
            r_s1_col       <= r_col_pos;
            r_s1_frame_end <= w_col_wrap && w_row_wrap;
        end
    end

    // neighbour registers move on as the pixel leaves stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_above_left <= '0;
        end else if (w_s1_adv) begin
            r_left       <= r_s1_pixel;
            r_above_left <= w_above;
        end
    end

    assign w_p         = sext(r_s1_pixel);
    assign w_l         = sext(r_left);
    assign w_a         = sext(w_above);
    assign w_al        = sext(r_above_left);
    assign w_sum_left  = w_l + w_p;
    assign w_sum_above = w_a + w_p;
    assign w_row2      = COORD_BITS'({r_s1_row, 1'b0});
    assign w_col2      = COORD_BITS'({r_s1_col, 1'b0});

    always_comb begin
        w_load.present              = '0;
        w_load.present[KIND_COPY]   = 1'b1;
        w_load.present[KIND_LEFT]   = (r_s1_col != '0);
        w_load.present[KIND_ABOVE]  = (r_s1_row != '0);
        w_load.present[KIND_CORNER] = (r_s1_col != '0) && (r_s1_row != '0);
        w_load.value[KIND_COPY]     = {w_p[OUT_BITS-3:0], 2'b00};
        w_load.value[KIND_LEFT]     = {w_sum_left[OUT_BITS-2:0], 1'b0};
        w_load.value[KIND_ABOVE]    = {w_sum_above[OUT_BITS-2:0], 1'b0};
        w_load.value[KIND_CORNER]   = w_al + w_sum_above + w_l;
        w_load.row_even             = w_row2;
        w_load.row_odd              = w_row2 - COORD_BITS'(1);
        w_load.col_even             = w_col2;
        w_load.col_odd              = w_col2 - COORD_BITS'(1);
        w_load.frame_end            = r_s1_frame_end;
    end

    // ---------------------------------------------------------------- output
    bu2x_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_s1_valid),
        .i_load       (w_load),
        .o_load_ready (w_em_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_value      (w_out_value),
        .o_row        (w_out_row),
        .o_col        (w_out_col),
        .o_last       (w_out_last),
        .o_frame_done (w_out_frame)
    );

    assign m_axis_tdata = {w_out_col, w_out_row, w_out_value};
    assign m_axis_tlast = w_out_last;
    assign m_axis_tuser = w_out_frame;

    a_frame_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("frame end flagged on a result that is not the last of its pixel");

endmodule

`default_nettype wire
